>>> sv/cms_pkg.sv
// ----------------------------------------------------------------------------
// Count-min sketch package
// Shared constants, types and hash helpers for the count-min sketch block.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    localparam int unsigned DEF_MAX_ROWS     = 8;
    localparam int unsigned DEF_MAX_WIDTH    = 1024;
    localparam int unsigned DEF_COUNTER_BITS = 32;

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam int unsigned SALT_COUNT = 8;

    localparam logic [3:0]  RESET_ROWS     = 4'd4;
    localparam logic [10:0] RESET_WIDTH    = 11'd1024;
    localparam logic [63:0] RESET_INTERVAL = 64'd1000000000;

    typedef enum logic [1:0] {
        ACT_INC   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_ROWS     = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_INTERVAL = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HASH,
        ST_DIV,
        ST_READ,
        ST_WAIT,
        ST_UPDATE,
        ST_TICK,
        ST_DONE
    } state_t;

    // One queued request between the front and back parts.
    typedef struct packed {
        action_t     action;
        logic [31:0] key_digest;
        logic [63:0] now;
    } request_t;

    // Row salt table.
    function automatic logic [31:0] row_salt(input logic [2:0] r);
        logic [31:0] s;
        begin
            case (r)
                3'd0: s = 32'h9b78350f;
                3'd1: s = 32'h9bcf144c;
                3'd2: s = 32'h8ab29a3e;
                3'd3: s = 32'h34d48bf5;
                3'd4: s = 32'h78e47449;
                3'd5: s = 32'hd6e4af1d;
                3'd6: s = 32'h32ed75e2;
                default: s = 32'hb1eb5a08;
            endcase
            return s;
        end
    endfunction

    // Eight reflected CRC32C bit steps; four calls fold one 32-bit word.
    function automatic logic [31:0] crc_step8(input logic [31:0] c);
        logic [31:0] x;
        begin
            x = c;
            for (int i = 0; i < 8; i++) begin
                x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
            end
            return x;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/cms_front.sv
// ----------------------------------------------------------------------------
// Count-min sketch front end
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_front
    import cms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] key_digest,
    input  wire logic [63:0] now,
    output logic             q_valid,
    output request_t         q_req,
    input  wire logic        q_pop
);

    request_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    // The queue is full at two requests.
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];

    // Pointer and count update.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{action: action_t'(action), key_digest: key_digest, now: now};
        end
    end

endmodule

`default_nettype wire

>>> sv/cms_back.sv
// ----------------------------------------------------------------------------
// Count-min sketch back end
// Hashes, divides, and updates or reads the counter memory one row at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_back
    import cms_pkg::*;
#(
    parameter int unsigned MAX_ROWS     = DEF_MAX_ROWS,
    parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  request_t         q_req,
    output logic             q_pop,
    input  wire logic [3:0]  rows_in_use,
    input  wire logic [10:0] row_width,
    input  wire logic [63:0] clear_period,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      estimate,
    output logic             cleared
);

    localparam int unsigned DEPTH     = MAX_ROWS * MAX_WIDTH;
    localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned ROWC_BITS = $clog2(MAX_ROWS + 1);
    localparam int unsigned WIDC_BITS = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EFF_ROWS  = (MAX_ROWS < SALT_COUNT) ? MAX_ROWS : SALT_COUNT;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [COUNTER_BITS-1:0] mem [DEPTH];
    logic [COUNTER_BITS-1:0] rdata_reg;

    state_t                  state_reg, state_next;
    request_t                req_reg, req_next;
    logic [ROWC_BITS-1:0]    row_reg, row_next;
    logic [ROWC_BITS-1:0]    nrows_reg, nrows_next;
    logic [WIDC_BITS-1:0]    width_reg, width_next;
    logic [1:0]              sub_reg, sub_next;
    logic [31:0]             crc_reg, crc_next;
    logic [31:0]             rem_reg, rem_next;
    logic [5:0]              bit_reg, bit_next;
    logic [ADDR_BITS-1:0]    addr_reg, addr_next;
    logic [COUNTER_BITS-1:0] min_reg, min_next;
    logic [63:0]             last_reg, last_next;
    logic [ADDR_BITS:0]      sweep_reg, sweep_next;
    logic                    ov_reg, ov_next;
    logic [31:0]             est_reg, est_next;
    logic                    clr_reg, clr_next;
    logic [31:0]             res_est_reg, res_est_next;
    logic                    res_clr_reg, res_clr_next;

    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;
    logic [32:0]             trial;
    logic [63:0]             elapsed;

    assign out_valid = ov_reg;
    assign estimate  = est_reg;
    assign cleared   = clr_reg;

    // Control sequencer.
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        row_next     = row_reg;
        nrows_next   = nrows_reg;
        width_next   = width_reg;
        sub_next     = sub_reg;
        crc_next     = crc_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        addr_next    = addr_reg;
        min_next     = min_reg;
        last_next    = last_reg;
        sweep_next   = sweep_reg;
        ov_next      = ov_reg && out_stall;
        est_next     = est_reg;
        clr_next     = clr_reg;
        res_est_next = res_est_reg;
        res_clr_next = res_clr_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = '0;
        trial        = {rem_reg, crc_reg[31]} - 33'(width_reg);
        elapsed      = req_reg.now - last_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[ADDR_BITS-1:0];
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (ADDR_BITS+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    req_next = q_req;
                    row_next = '0;
                    min_next = CNT_MAX;
                    if (rows_in_use == 4'd0)
                        nrows_next = ROWC_BITS'(1);
                    else if (32'(rows_in_use) > EFF_ROWS)
                        nrows_next = ROWC_BITS'(EFF_ROWS);
                    else
                        nrows_next = ROWC_BITS'(rows_in_use);
                    if (row_width == 11'd0)
                        width_next = WIDC_BITS'(1);
                    else if (32'(row_width) > MAX_WIDTH)
                        width_next = WIDC_BITS'(MAX_WIDTH);
                    else
                        width_next = WIDC_BITS'(row_width);
                    unique case (q_req.action)
                        ACT_INC, ACT_QUERY:
                        begin
                            crc_next   = row_salt(3'd0) ^ q_req.key_digest;
                            sub_next   = 2'd0;
                            state_next = ST_HASH;
                        end
                        ACT_TICK:  state_next = ST_TICK;
                        default:
                        begin
                            res_est_next = '0;
                            res_clr_next = 1'b0;
                            state_next   = ST_DONE;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                crc_next = crc_step8(crc_reg);
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring remainder, one dividend bit per cycle.
                crc_next = {crc_reg[30:0], 1'b0};
                if (!trial[32])
                    rem_next = trial[31:0];
                else
                    rem_next = {rem_reg[30:0], crc_reg[31]};
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd31)
                begin
                    addr_next = ADDR_BITS'(32'(row_reg) * MAX_WIDTH
                                + (!trial[32] ? trial[31:0] : {rem_reg[30:0], crc_reg[31]}));
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (req_reg.action == ACT_INC)
                begin
                    mem_we    = (rdata_reg != CNT_MAX);
                    mem_wdata = rdata_reg + 1'b1;
                end
                else if (rdata_reg < min_reg)
                begin
                    min_next = rdata_reg;
                end
                row_next = row_reg + 1'b1;
                if (row_reg + 1'b1 == nrows_reg)
                begin
                    res_clr_next = 1'b0;
                    if (req_reg.action == ACT_INC)
                        res_est_next = '0;
                    else if (rdata_reg < min_reg)
                        res_est_next =
                            (COUNTER_BITS > 32 && rdata_reg > COUNTER_BITS'(32'hFFFFFFFF))
                            ? 32'hFFFFFFFF : 32'(rdata_reg);
                    else
                        res_est_next =
                            (COUNTER_BITS > 32 && min_reg > COUNTER_BITS'(32'hFFFFFFFF))
                            ? 32'hFFFFFFFF : 32'(min_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    crc_next   = row_salt(3'(row_reg + 1'b1)) ^ req_reg.key_digest;
                    sub_next   = 2'd0;
                    state_next = ST_HASH;
                end
            end
            ST_TICK:
            begin
                res_est_next = '0;
                res_clr_next = 1'b0;
                state_next   = ST_DONE;
                if (last_reg == 64'd0)
                    last_next = req_reg.now;
                else if (elapsed >= clear_period)
                begin
                    last_next    = req_reg.now;
                    res_clr_next = 1'b1;
                    sweep_next   = '0;
                end
            end
            ST_DONE:
            begin
                // The finished result moves to the output once it is free.
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    est_next   = res_est_reg;
                    clr_next   = res_clr_reg;
                    state_next = res_clr_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        row_reg     <= row_next;
        nrows_reg   <= nrows_next;
        width_reg   <= width_next;
        sub_reg     <= sub_next;
        crc_reg     <= crc_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        addr_reg    <= addr_next;
        min_reg     <= min_next;
        est_reg     <= est_next;
        clr_reg     <= clr_next;
        res_est_reg <= res_est_next;
        res_clr_reg <= res_clr_next;
    end

    // Counter memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[addr_reg];
    end

endmodule

`default_nettype wire

>>> sv/count_min_sketch_top.sv
// ----------------------------------------------------------------------------
// Count-min sketch top level
// Configuration registers plus the front queue and the back-end sequencer.
// ----------------------------------------------------------------------------
// An increment or query is sequenced per row in use: the hash, a bit-serial
// remainder of the hash by the row width, a memory read, a read wait and an
// update; the request is first taken from the queue and the result posted at
// the end. A tick takes the request, checks the interval and posts a result.
// After reset, and after every tick that clears, all MAX_ROWS*MAX_WIDTH
// entries of the counter memory (8192 by default) are swept to zero one entry
// per cycle while the sequencer takes nothing from the queue. A
// two-entry queue lets the input side run ahead of the sequencer, and a
// finished result waits in its own register while the output is stalled.
`default_nettype none

module count_min_sketch_top
    import cms_pkg::*;
#(
    parameter int unsigned MAX_ROWS     = DEF_MAX_ROWS,
    parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] key_digest,
    input  wire logic [63:0] now,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      estimate,
    output logic             cleared,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [3:0]  rows_reg;
    logic [10:0] width_reg;
    logic [63:0] interval_reg;
    logic        q_valid, q_pop;
    request_t    q_req;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= RESET_ROWS;
            width_reg    <= RESET_WIDTH;
            interval_reg <= RESET_INTERVAL;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_ROWS:     rows_reg     <= cfg_data[3:0];
                REG_WIDTH:    width_reg    <= cfg_data[10:0];
                REG_INTERVAL: interval_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    cms_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .key_digest(key_digest), .now(now),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
    );

    cms_back #(
        .MAX_ROWS(MAX_ROWS), .MAX_WIDTH(MAX_WIDTH), .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
        .rows_in_use(rows_reg), .row_width(width_reg),
        .clear_period(interval_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .estimate(estimate), .cleared(cleared)
    );

endmodule

`default_nettype wire

>>> sv/cms_checker.sv
// ----------------------------------------------------------------------------
// Count-min sketch port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] estimate,
    input wire logic        cleared
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(cleared))
        else $error("stalled result changed");

    // A clear report never carries an estimate.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cleared |-> estimate == 32'd0)
        else $error("clear report with estimate");

    // After a clear, the sweep keeps back-to-back results from following.
    a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && cleared |=> !out_valid)
        else $error("result during clearing sweep");

endmodule

bind count_min_sketch_top cms_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .estimate(estimate), .cleared(cleared)
);

`default_nettype wire

>>> test/count_min_sketch_top_tb.sv
// ----------------------------------------------------------------------------
// Count-min sketch testbench
// Drives increments, queries and cleanup ticks into the sketch and checks
// every estimate and clear flag against a behavioral model kept in the bench.
// The bench reprograms rows, width and interval between phases and varies
// the backpressure on both channels.
// ----------------------------------------------------------------------------
module count_min_sketch_top_tb;
    import cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SKETCH_ROWS  = 8;
    localparam int unsigned SKETCH_WIDTH = 1024;
    localparam int unsigned SKETCH_DEPTH = SKETCH_ROWS * SKETCH_WIDTH;
    localparam int unsigned IDLE_PAUSE   = 400;
    localparam int unsigned STALL_LIMIT  = 100000;
    localparam reg_index_t  REG_INDEX_SPARE = reg_index_t'(2'd3);

    typedef struct {
        logic [31:0] estimate;
        logic        cleared;
    } sketch_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] key_digest;
    logic [63:0] now;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] estimate;
    logic        cleared;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // Bench copy of the sketch state and registers.
    logic [31:0]    sketch_mem [SKETCH_DEPTH];
    logic [63:0]    last_clear_time;
    logic [3:0]     rows_reg;
    logic [10:0]    width_reg;
    logic [63:0]    interval_reg;
    sketch_result_t pending_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned error_count;
    int unsigned quiet_cycles;

    count_min_sketch_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key_digest (key_digest),
        .now        (now),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .estimate   (estimate),
        .cleared    (cleared),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One reflected CRC32C fold of a 32-bit word.
    function automatic logic [31:0] crc32c_fold(input logic [31:0] seed,
                                                 input logic [31:0] word);
        logic [31:0] c;
        c = seed ^ word;
        for (int i = 0; i < 32; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] salt_of(input int unsigned r);
        logic [31:0] salts [8];
        salts = '{32'h9b78350f, 32'h9bcf144c, 32'h8ab29a3e, 32'h34d48bf5,
                  32'h78e47449, 32'hd6e4af1d, 32'h32ed75e2, 32'hb1eb5a08};
        return salts[r];
    endfunction

    // Applies one request to the bench sketch and returns its result.
    function automatic sketch_result_t apply_request(input action_t a,
                                                     input logic [31:0] k,
                                                     input logic [63:0] t);
        sketch_result_t res;
        int unsigned    rows;
        int unsigned    width;
        int unsigned    slot;
        logic [31:0]    lowest;
        res.estimate = '0;
        res.cleared  = 1'b0;
        rows  = (rows_reg == 0) ? 1 : ((rows_reg > SKETCH_ROWS) ? SKETCH_ROWS : rows_reg);
        width = (width_reg == 0) ? 1 : ((width_reg > SKETCH_WIDTH) ? SKETCH_WIDTH : width_reg);
        lowest = '1;
        case (a)
            ACT_INC:
            begin
                for (int r = 0; r < rows; r++)
                begin
                    slot = r * SKETCH_WIDTH + (crc32c_fold(salt_of(r), k) % width);
                    if (sketch_mem[slot] != '1)
                        sketch_mem[slot] = sketch_mem[slot] + 32'd1;
                end
            end
            ACT_QUERY:
            begin
                for (int r = 0; r < rows; r++)
                begin
                    slot = r * SKETCH_WIDTH + (crc32c_fold(salt_of(r), k) % width);
                    if (sketch_mem[slot] < lowest)
                        lowest = sketch_mem[slot];
                end
                res.estimate = lowest;
            end
            ACT_TICK:
            begin
                if (last_clear_time == 0)
                    last_clear_time = t;
                else if (t - last_clear_time >= interval_reg)
                begin
                    for (int i = 0; i < SKETCH_DEPTH; i++)
                        sketch_mem[i] = '0;
                    last_clear_time = t;
                    res.cleared = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic note_error(input string msg);
        if (error_count < 10)
            $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sends one request; the result is predicted when it is accepted.
    task automatic send_request(input action_t a, input logic [31:0] k,
                                input logic [63:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = a;
        key_digest = k;
        now        = t;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_request(a, k, t));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Writes one register once all results are back and after an idle pause.
    task automatic write_reg(input reg_index_t idx, input logic [63:0] data);
        wait (pending_results.size() == 0);
        repeat (IDLE_PAUSE) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ROWS:     rows_reg = data[3:0];
            REG_WIDTH:    width_reg = data[10:0];
            REG_INTERVAL: interval_reg = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_shape(input logic [3:0] rows, input logic [10:0] width);
        write_reg(REG_ROWS, {$urandom, 28'($urandom), rows});
        write_reg(REG_WIDTH, {$urandom, 21'($urandom), width});
    endtask

    // Random request with mostly increments and queries on a small key pool, or on any key when the pool is zero.
    task automatic send_random(input int unsigned key_pool);
        int unsigned pick;
        logic [31:0] k;
        logic [63:0] t;
        pick = $urandom_range(99);
        k = (key_pool == 0) ? $urandom : $urandom_range(key_pool);
        if ($urandom_range(9) == 0)
            t = {$urandom, $urandom};
        else
            t = last_clear_time + $urandom_range(3000);
        if (pick < 50)
            send_request(ACT_INC, k, t);
        else if (pick < 92)
            send_request(ACT_QUERY, k, t);
        else if (pick < 97)
            send_request(ACT_TICK, k, t);
        else
            send_request(ACT_NONE, k, t);
    endtask

    // Extremes of the fields, each action, and the tick corner cases.
    task automatic test_directed();
        send_request(ACT_TICK, 32'h0, 64'h0);
        send_request(ACT_QUERY, 32'h0, 64'h0);
        send_request(ACT_INC, 32'hFFFF_FFFF, '1);
        send_request(ACT_INC, 32'hFFFF_FFFF, 64'h0);
        send_request(ACT_INC, 32'h0, 64'h0);
        send_request(ACT_QUERY, 32'hFFFF_FFFF, 64'h0);
        send_request(ACT_QUERY, 32'h0, '1);
        send_request(ACT_NONE, 32'hFFFF_FFFF, '1);
        send_request(ACT_QUERY, 32'h1, 64'h0);
        send_request(ACT_TICK, 32'h0, 64'd5);
        send_request(ACT_TICK, 32'h0, 64'd5 + 64'd999_999_999);
        send_request(ACT_QUERY, 32'hFFFF_FFFF, 64'h0);
        // Time going back counts as a very long interval.
        send_request(ACT_TICK, 32'h0, 64'd4);
        send_request(ACT_QUERY, 32'hFFFF_FFFF, 64'h0);
        send_request(ACT_TICK, 32'hFFFF_FFFF, '1);
    endtask

    // Out-of-range shapes, single counters and interval extremes.
    task automatic test_config_extremes();
        set_shape(4'd0, 11'd0);
        for (int i = 0; i < 12; i++)
            send_random(3);
        set_shape(4'd15, 11'd2047);
        for (int i = 0; i < 12; i++)
            send_random(0);
        set_shape(4'd8, 11'd1);
        write_reg(REG_INTERVAL, 64'h0);
        for (int i = 0; i < 12; i++)
            send_random(7);
        set_shape(4'd1, 11'd1024);
        write_reg(REG_INTERVAL, '1);
        for (int i = 0; i < 12; i++)
            send_random(15);
        // An index past the register list must leave everything unchanged.
        write_reg(REG_INDEX_SPARE, {$urandom, $urandom});
        for (int i = 0; i < 8; i++)
            send_random(15);
    endtask

    // Random traffic under three backpressure profiles.
    task automatic test_random();
        int unsigned idle_table  [3] = '{20, 61, 0};
        int unsigned stall_table [3] = '{61, 20, 0};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = idle_table[p];
            recv_stall_pct = stall_table[p];
            for (int s = 0; s < 4; s++)
            begin
                set_shape(4'($urandom_range(9)), 11'($urandom_range(1, 64)));
                write_reg(REG_INTERVAL, 64'($urandom_range(3000)));
                for (int i = 0; i < 55; i++)
                    send_random($urandom_range(40));
            end
        end
    endtask

    // Random stall on the result side, changed at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        sketch_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_error($sformatf("unexpected result estimate=%0d cleared=%0b",
                                     estimate, cleared));
            else
            begin
                exp_res = pending_results.pop_front();
                if (estimate !== exp_res.estimate)
                    note_error($sformatf("estimate expected %0d got %0d",
                                         exp_res.estimate, estimate));
                if (cleared !== exp_res.cleared)
                    note_error($sformatf("cleared expected %0b got %0b",
                                         exp_res.cleared, cleared));
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_INC;
        key_digest     = '0;
        now            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_ROWS;
        cfg_data       = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rows_reg       = RESET_ROWS;
        width_reg      = RESET_WIDTH;
        interval_reg   = RESET_INTERVAL;
        last_clear_time = '0;
        for (int i = 0; i < SKETCH_DEPTH; i++)
            sketch_mem[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random();

        wait (pending_results.size() == 0);
        repeat (IDLE_PAUSE) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
